// ===== rtl/tlpw_pkg.sv =====
// Shared types, codes and helpers for the two-level page walker.
package tlpw_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned DataW    = 32;
  localparam int unsigned LenW     = 3;
  localparam int unsigned FrameW   = 20;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned KindW    = 2;
  localparam int unsigned FaultW   = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 20;

  // Packed beat widths, rounded up to whole bytes.
  localparam int unsigned InBitsW  = AddrW + LenW + DataW + DataW;
  localparam int unsigned InTdataW = ((InBitsW + 7) / 8) * 8;
  localparam int unsigned OutBitsW = AddrW + LenW + DataW + DataW + FaultW;
  localparam int unsigned OutTdataW = ((OutBitsW + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RESP  = 2'd2,
    CMD_RESP3 = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_FAULT = 2'd3
  } kind_e;

  typedef enum logic [FaultW-1:0] {
    FLT_NONE      = 3'd0,
    FLT_DIR_ABS   = 3'd1,
    FLT_TAB_ABS   = 3'd2,
    FLT_CROSS_WR  = 3'd3,
    FLT_BAD_LEN   = 3'd4
  } fault_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_DIR  = 3'd1,
    PH_TAB  = 3'd2,
    PH_DATA = 3'd3,
    PH_BYTE = 3'd4
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAGING_EN = 1'd0,
    REG_DIR_BASE  = 1'd1
  } reg_e;

  typedef struct packed {
    phase_e            phase;
    logic [AddrW-1:0]  held_address;
    logic [LenW-1:0]   held_length;
    logic              held_is_write;
    logic [DataW-1:0]  held_store_data;
    logic [FrameW-1:0] first_frame;
    logic [FrameW-1:0] second_frame;
    logic [LenW-1:0]   byte_index;
    logic [DataW-1:0]  assembled_word;
    logic              walking_second_page;
  } walk_state_t;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [AddrW-1:0] virtual_address;
    logic [LenW-1:0]  access_length;
    logic [DataW-1:0] write_data;
    logic [DataW-1:0] memory_data;
  } item_t;

  typedef struct packed {
    kind_e            result_kind;
    logic [AddrW-1:0] memory_address;
    logic [LenW-1:0]  request_length;
    logic [DataW-1:0] store_data;
    logic [DataW-1:0] load_data;
    fault_e           fault_code;
  } result_t;

  // Keep the low len bytes of v; lengths of four and up keep the whole word.
  function automatic logic [DataW-1:0] mask_bytes(logic [DataW-1:0] v, logic [LenW-1:0] len);
    logic [DataW-1:0] r;
    case (len)
      3'd0:    r = '0;
      3'd1:    r = {24'h0, v[7:0]};
      3'd2:    r = {16'h0, v[15:0]};
      3'd3:    r = {8'h0, v[23:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tlpw_step.sv =====
// Combinational next-state and result logic for one beat of the walker.
module tlpw_step (
  input  tlpw_pkg::walk_state_t          st_i,
  input  tlpw_pkg::item_t                item_i,
  input  logic                           paging_en_i,
  input  logic [tlpw_pkg::FrameW-1:0]    dir_base_i,
  output tlpw_pkg::walk_state_t          st_o,
  output tlpw_pkg::result_t              res_o
);
  import tlpw_pkg::*;

  // Address of byte k of a split read: first page, then second.
  function automatic logic [AddrW-1:0] byte_addr(logic [AddrW-1:0] ha, logic [FrameW-1:0] f1,
                                                  logic [FrameW-1:0] f2, logic [LenW-1:0] k);
    logic [12:0] off;
    logic [12:0] len1;
    logic [12:0] kk;
    logic [12:0] rem;
    off  = {1'b0, ha[11:0]};
    len1 = 13'h1000 - off;
    kk   = {10'h0, k};
    rem  = kk - len1;
    if (kk < len1) begin
      return {f1, 12'h0} + {19'h0, off} + {29'h0, k};
    end else begin
      return {f2, 12'h0} + {19'h0, rem};
    end
  endfunction

  logic              is_req;
  logic              len_ok;
  logic [12:0]       cross_sum;
  logic              crosses_new;
  logic              crosses_held;
  logic [19:0]       walk_page;
  logic [AddrW-1:0]  dir_addr;
  logic [FrameW-1:0] frame;
  logic [DataW-1:0]  asm_next;
  logic [LenW-1:0]   idx_next;
  logic [DataW-1:0]  sd_new;

  always_comb begin
    is_req = (item_i.command == CMD_READ) || (item_i.command == CMD_WRITE);
    if (item_i.command == CMD_READ) begin
      len_ok = (item_i.access_length == 3'd1) || (item_i.access_length == 3'd2) ||
               (item_i.access_length == 3'd4);
    end else begin
      len_ok = (item_i.access_length >= 3'd1) && (item_i.access_length <= 3'd4);
    end
    cross_sum    = {1'b0, item_i.virtual_address[11:0]} + {10'h0, item_i.access_length};
    crosses_new  = cross_sum > 13'h1000;
    crosses_held = ({1'b0, st_i.held_address[11:0]} + {10'h0, st_i.held_length}) > 13'h1000;
    sd_new       = mask_bytes(item_i.write_data, item_i.access_length);
    frame        = item_i.memory_data[31:12];
    asm_next     = {st_i.assembled_word[23:0], item_i.memory_data[7:0]};
    idx_next     = st_i.byte_index - 3'd1;
    walk_page    = st_i.held_address[31:12];
    dir_addr     = '0;

    st_o  = st_i;
    res_o = '{result_kind: KIND_READ, memory_address: '0, request_length: '0,
              store_data: '0, load_data: '0, fault_code: FLT_NONE};

    if (is_req) begin
      st_o.held_address        = item_i.virtual_address;
      st_o.held_length         = item_i.access_length;
      st_o.held_is_write       = (item_i.command == CMD_WRITE);
      st_o.held_store_data     = sd_new;
      st_o.walking_second_page = 1'b0;
      st_o.byte_index          = '0;
      st_o.assembled_word      = '0;
      dir_addr = {dir_base_i, item_i.virtual_address[31:22], 2'b00};
      if (!len_ok) begin
        st_o.phase        = PH_IDLE;
        res_o.result_kind = KIND_FAULT;
        res_o.fault_code  = FLT_BAD_LEN;
      end else if (!paging_en_i) begin
        res_o.memory_address = item_i.virtual_address;
        res_o.request_length = item_i.access_length;
        if (item_i.command == CMD_WRITE) begin
          st_o.phase        = PH_IDLE;
          res_o.result_kind = KIND_WRITE;
          res_o.store_data  = sd_new;
        end else begin
          st_o.phase        = PH_DATA;
          res_o.result_kind = KIND_READ;
        end
      end else if ((item_i.command == CMD_WRITE) && crosses_new) begin
        st_o.phase        = PH_IDLE;
        res_o.result_kind = KIND_FAULT;
        res_o.fault_code  = FLT_CROSS_WR;
      end else begin
        st_o.phase           = PH_DIR;
        res_o.memory_address = dir_addr;
        res_o.request_length = 3'd4;
      end
    end else begin
      // second-page walk uses the page after the held address
      walk_page = st_i.held_address[31:12] + {19'h0, st_i.walking_second_page};
      case (st_i.phase)
        PH_DIR: begin
          if (!item_i.memory_data[0]) begin
            st_o.phase               = PH_IDLE;
            st_o.walking_second_page = 1'b0;
            res_o.result_kind        = KIND_FAULT;
            res_o.fault_code         = FLT_DIR_ABS;
          end else begin
            st_o.phase           = PH_TAB;
            res_o.memory_address = {item_i.memory_data[31:12], walk_page[9:0], 2'b00};
            res_o.request_length = 3'd4;
          end
        end
        PH_TAB: begin
          if (!item_i.memory_data[0]) begin
            st_o.phase               = PH_IDLE;
            st_o.walking_second_page = 1'b0;
            res_o.result_kind        = KIND_FAULT;
            res_o.fault_code         = FLT_TAB_ABS;
          end else if (st_i.walking_second_page) begin
            st_o.second_frame        = frame;
            st_o.walking_second_page = 1'b0;
            st_o.byte_index          = st_i.held_length - 3'd1;
            st_o.assembled_word      = '0;
            st_o.phase               = PH_BYTE;
            res_o.memory_address     = byte_addr(st_i.held_address, st_i.first_frame, frame,
                                                 st_i.held_length - 3'd1);
            res_o.request_length     = 3'd1;
          end else begin
            st_o.first_frame = frame;
            if (!st_i.held_is_write && crosses_held) begin
              // read spans two pages: walk the next page too
              st_o.walking_second_page = 1'b1;
              st_o.phase               = PH_DIR;
              walk_page                = st_i.held_address[31:12] + 20'd1;
              res_o.memory_address     = {dir_base_i, walk_page[19:10], 2'b00};
              res_o.request_length     = 3'd4;
            end else if (st_i.held_is_write) begin
              st_o.phase           = PH_IDLE;
              res_o.result_kind    = KIND_WRITE;
              res_o.memory_address = {frame, st_i.held_address[11:0]};
              res_o.request_length = st_i.held_length;
              res_o.store_data     = st_i.held_store_data;
            end else begin
              st_o.phase           = PH_DATA;
              res_o.memory_address = {frame, st_i.held_address[11:0]};
              res_o.request_length = st_i.held_length;
            end
          end
        end
        PH_DATA: begin
          st_o.phase        = PH_IDLE;
          res_o.result_kind = KIND_DONE;
          res_o.load_data   = mask_bytes(item_i.memory_data, st_i.held_length);
        end
        PH_BYTE: begin
          st_o.assembled_word = asm_next;
          if (st_i.byte_index == 3'd0) begin
            st_o.phase        = PH_IDLE;
            res_o.result_kind = KIND_DONE;
            res_o.load_data   = asm_next;
          end else begin
            st_o.byte_index      = idx_next;
            res_o.memory_address = byte_addr(st_i.held_address, st_i.first_frame,
                                             st_i.second_frame, idx_next);
            res_o.request_length = 3'd1;
          end
        end
        default: begin
          // response with no walk pending
          st_o.phase               = PH_IDLE;
          st_o.walking_second_page = 1'b0;
          res_o.result_kind        = KIND_FAULT;
          res_o.fault_code         = FLT_NONE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/two_level_page_walker_unit.sv =====
// Top level of the two-level page walker: beat registers, walk state and config.
// Two-level page walker, 32-bit x86 style with 4 KiB pages. Each slave beat is
// an access request (read or write) or a memory read response, and produces
// exactly one master beat: the next memory request (directory entry, table
// entry or data access), a read completion, or a fault. The block takes one
// beat per clock and returns one beat per clock while the sink keeps taking
// results. An accepted beat is held in the input register and is executed
// from there into the result register, where the sink takes it. A result
// held by the sink keeps the input register occupied, so the slave side stalls
// once both registers are full. The per-beat work is one pass of the step
// logic between those two registers, which also updates the walk state, so
// back-to-back beats see the state left by the previous one. Config writes
// (index 0: paging enable, index 1: directory base frame) are always taken and
// should be made only while no walk is in flight.
module two_level_page_walker_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave stream
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // tdata: virtual_address[31:0], access_length[34:32], write_data[66:35],
  //        memory_data[98:67], zero pad
  input  logic [tlpw_pkg::InTdataW-1:0]      s_tdata_i,
  // tuser: command[1:0]
  input  logic [tlpw_pkg::CmdW-1:0]          s_tuser_i,
  // master stream
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // tdata: memory_address[31:0], request_length[34:32], store_data[66:35],
  //        load_data[98:67], fault_code[101:99], zero pad
  output logic [tlpw_pkg::OutTdataW-1:0]     m_tdata_o,
  // tuser: result_kind[1:0]
  output logic [tlpw_pkg::KindW-1:0]         m_tuser_o,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tlpw_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tlpw_pkg::CfgDataW-1:0]      cfg_data_i
);
  import tlpw_pkg::*;

  logic              in_valid_q;
  item_t             in_item_q;
  logic              out_valid_q;
  result_t           out_res_q;
  walk_state_t       st_q, st_d;
  result_t           res_d;
  logic              paging_en_q;
  logic [FrameW-1:0] dir_base_q;
  logic              exec;
  item_t             s_item;

  // unpack slave beat
  always_comb begin
    s_item.command         = s_tuser_i;
    s_item.virtual_address = s_tdata_i[31:0];
    s_item.access_length   = s_tdata_i[34:32];
    s_item.write_data      = s_tdata_i[66:35];
    s_item.memory_data     = s_tdata_i[98:67];
  end

  // an item in the input register moves on when the result register frees up
  assign exec        = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o  = !in_valid_q || exec;
  assign cfg_ready_o = 1'b1;

  tlpw_step u_step (
    .st_i        (st_q),
    .item_i      (in_item_q),
    .paging_en_i (paging_en_q),
    .dir_base_i  (dir_base_q),
    .st_o        (st_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{phase: PH_IDLE, default: '0};
      paging_en_q <= 1'b0;
      dir_base_q  <= '0;
    end else begin
      if (s_tready_o) begin
        in_valid_q <= s_tvalid_i;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PAGING_EN: paging_en_q <= cfg_data_i[0];
          REG_DIR_BASE:  dir_base_q  <= cfg_data_i;
          default:       ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_item_q <= s_item;
    end
    if (exec) begin
      out_res_q <= res_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_res_q.result_kind;
  assign m_tdata_o  = {{(OutTdataW - OutBitsW){1'b0}}, out_res_q.fault_code,
                       out_res_q.load_data, out_res_q.store_data,
                       out_res_q.request_length, out_res_q.memory_address};

endmodule
